/* design/mmc3bm_pkg.sv */
// Shared constants for the MMC3-style bank mapper with scanline IRQ.
// Request codes, register decode addresses, configuration indexes and reset values.
// No dependencies.
package mmc3bm_pkg;

	// Request codes
	localparam logic [2:0] REQ_CPU_WRITE = 3'd0;
	localparam logic [2:0] REQ_TICK      = 3'd1;
	localparam logic [2:0] REQ_PRG_QUERY = 3'd2;
	localparam logic [2:0] REQ_CHR_QUERY = 3'd3;
	localparam logic [2:0] REQ_LOW_READ  = 3'd4;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM_BANKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN    = 2'd2;

	// High-area register decode (address & ADDR_DECODE_MASK)
	localparam logic [15:0] ADDR_DECODE_MASK  = 16'hE001;
	localparam logic [15:0] ADDR_BANK_SELECT  = 16'h8000;
	localparam logic [15:0] ADDR_BANK_DATA    = 16'h8001;
	localparam logic [15:0] ADDR_MIRRORING    = 16'hA000;
	localparam logic [15:0] ADDR_IRQ_LATCH    = 16'hC000;
	localparam logic [15:0] ADDR_IRQ_RELOAD   = 16'hC001;
	localparam logic [15:0] ADDR_IRQ_DISABLE  = 16'hE000;
	localparam logic [15:0] ADDR_IRQ_ENABLE   = 16'hE001;

	// Low-area window bounds (exclusive on both sides)
	localparam logic [15:0] ADDR_LOW_FLOOR = 16'h4100;
	localparam logic [15:0] ADDR_LOW_CEIL  = 16'h6000;
	localparam logic [15:0] ADDR_CHR_END   = 16'h2000;

	// Bank register targets of bank_select[2:0]
	localparam logic [2:0] SEL_CHR_PAIR_A = 3'd0;
	localparam logic [2:0] SEL_CHR_PAIR_B = 3'd1;
	localparam logic [2:0] SEL_CHR_S0     = 3'd2;
	localparam logic [2:0] SEL_CHR_S1     = 3'd3;
	localparam logic [2:0] SEL_CHR_S2     = 3'd4;
	localparam logic [2:0] SEL_CHR_S3     = 3'd5;
	localparam logic [2:0] SEL_PRG_FIRST  = 3'd6;
	localparam logic [2:0] SEL_PRG_SECOND = 3'd7;

	// Last visible scanline
	localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

	// Reset values
	localparam logic [8:0] RST_PRG_BANK_COUNT = 9'd32;
	localparam logic [9:0] RST_CHR_ROM_BANKS  = 10'd256;
	localparam logic [7:0] RST_IRQ_RELOAD     = 8'hFF;

endpackage

/* design/mmc3_style_bank_mapper_with_scanline_irq_unit.sv */
// MMC3-style cartridge bank mapper with CHR half offsets and scanline IRQ counter.
// Depends on mmc3bm_pkg.
//
// Takes one request per clock while out_stall is low (CPU write, scanline tick,
// PRG/CHR bank query or low-area read) and returns exactly one result per
// request. A request is held in an input register, where shallow decode updates
// the mapper registers and forms the answer, which is then held in the result
// register; out_valid rises once the request has moved from the input register
// into the result register, and the sustained rate is one request per cycle
// while out_stall stays low. While a result waits under out_stall the input
// register can still take one request, so up to two requests are in flight;
// after that in_stall rises until the result is taken. irq_line and
// mirror_horizontal report the state after the request was applied.
// Configuration writes (prg_bank_count, chr_rom_banks, four_screen) are taken
// on any cycle with cfg_we high and should only be issued when the unit is idle.
module mmc3_style_bank_mapper_with_scanline_irq_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [mmc3bm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mmc3bm_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         req_type,
	input  logic [15:0]                        address,
	input  logic [7:0]                         write_data,
	input  logic [8:0]                         scanline,
	input  logic                               rendering_on,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [8:0]                         bank,
	output logic                               bank_is_chr_ram,
	output logic [7:0]                         read_data,
	output logic                               irq_line,
	output logic                               mirror_horizontal
);
	import mmc3bm_pkg::*;

	// Configuration registers
	logic [8:0] prg_bank_count_q;
	logic [9:0] chr_rom_banks_q;
	logic       four_screen_q;

	// Mapper state
	logic [7:0] bank_select_q;
	logic [7:0] chr_pair_a_q;
	logic [7:0] chr_pair_b_q;
	logic [7:0] chr_single_q [4];
	logic [7:0] prg_first_q;
	logic [7:0] prg_second_q;
	logic       chr_low_off_q;
	logic       chr_high_off_q;
	logic       mirror_q;
	logic       irq_enabled_q;
	logic [7:0] irq_count_q;
	logic [7:0] irq_reload_q;
	logic       irq_pending_q;
	logic       reload_q;
	logic       reload_vblank_q;
	logic       irq_out_q;

	// Input register
	logic        valid_s1;
	logic [2:0]  type_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic [8:0]  line_s1;
	logic        rend_s1;

	// Result register
	logic        out_valid_q;

	logic advance;

	// Next state and answer
	logic [7:0] bank_select_d;
	logic [7:0] chr_pair_a_d;
	logic [7:0] chr_pair_b_d;
	logic [7:0] chr_single_d [4];
	logic [7:0] prg_first_d;
	logic [7:0] prg_second_d;
	logic       chr_low_off_d;
	logic       chr_high_off_d;
	logic       mirror_d;
	logic       irq_enabled_d;
	logic [7:0] irq_count_d;
	logic [7:0] irq_reload_d;
	logic       irq_pending_d;
	logic       reload_d;
	logic       reload_vblank_d;
	logic       irq_out_d;
	logic [8:0] bank_d;
	logic       is_ram_d;
	logic [7:0] rd_d;

	// Stage moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign out_valid = out_valid_q;

	// Request decode and state update
	always_comb begin
		logic [15:0] dec;
		logic [7:0]  cnt;
		logic [8:0]  second_last;
		logic [8:0]  last;
		logic [2:0]  win_c;
		logic [2:0]  slot;
		logic [7:0]  v8;
		logic [8:0]  v9;
		logic        ram;

		bank_select_d   = bank_select_q;
		chr_pair_a_d    = chr_pair_a_q;
		chr_pair_b_d    = chr_pair_b_q;
		chr_single_d    = chr_single_q;
		prg_first_d     = prg_first_q;
		prg_second_d    = prg_second_q;
		chr_low_off_d   = chr_low_off_q;
		chr_high_off_d  = chr_high_off_q;
		mirror_d        = mirror_q;
		irq_enabled_d   = irq_enabled_q;
		irq_count_d     = irq_count_q;
		irq_reload_d    = irq_reload_q;
		irq_pending_d   = irq_pending_q;
		reload_d        = reload_q;
		reload_vblank_d = reload_vblank_q;
		irq_out_d       = irq_out_q;
		bank_d          = '0;
		is_ram_d        = 1'b0;
		rd_d            = '0;

		dec         = addr_s1 & ADDR_DECODE_MASK;
		cnt         = irq_count_q;
		second_last = prg_bank_count_q - 9'd2;
		last        = prg_bank_count_q - 9'd1;
		win_c       = addr_s1[12:10];
		slot        = win_c ^ {bank_select_q[7], 2'b00};
		ram         = (chr_rom_banks_q == '0);

		// CHR register value for the 1K slot
		case (slot)
			3'd0:    v8 = chr_pair_a_q;
			3'd1:    v8 = chr_pair_a_q | 8'h01;
			3'd2:    v8 = chr_pair_b_q;
			3'd3:    v8 = chr_pair_b_q + 8'd1;
			default: v8 = chr_single_q[slot[1:0]];
		endcase
		v9 = {1'b0, v8};
		if (!win_c[2])
			v9[8] = chr_low_off_q;
		else
			v9[8] = chr_high_off_q;

		case (type_s1)
			REQ_CPU_WRITE: begin
				if (addr_s1 > ADDR_LOW_FLOOR && addr_s1 < ADDR_LOW_CEIL) begin
					chr_low_off_d  = data_s1[0];
					chr_high_off_d = data_s1[4];
				end else begin
					case (dec)
						ADDR_BANK_SELECT: bank_select_d = data_s1;
						ADDR_BANK_DATA: begin
							case (bank_select_q[2:0])
								SEL_CHR_PAIR_A: chr_pair_a_d    = data_s1 & 8'hFE;
								SEL_CHR_PAIR_B: chr_pair_b_d    = data_s1 & 8'hFE;
								SEL_CHR_S0:     chr_single_d[0] = data_s1;
								SEL_CHR_S1:     chr_single_d[1] = data_s1;
								SEL_CHR_S2:     chr_single_d[2] = data_s1;
								SEL_CHR_S3:     chr_single_d[3] = data_s1;
								SEL_PRG_FIRST:  prg_first_d     = data_s1;
								default:        prg_second_d    = data_s1;
							endcase
						end
						ADDR_MIRRORING: begin
							if (!four_screen_q)
								mirror_d = data_s1[0];
						end
						ADDR_IRQ_LATCH: irq_reload_d = data_s1;
						ADDR_IRQ_RELOAD: begin
							irq_count_d = irq_count_q | 8'h80;
							if (line_s1 <= LAST_VISIBLE_LINE) begin
								reload_d = 1'b1;
							end else begin
								reload_vblank_d = 1'b1;
								reload_d        = 1'b0;
							end
						end
						ADDR_IRQ_DISABLE: begin
							irq_enabled_d = 1'b0;
							irq_pending_d = 1'b0;
							irq_out_d     = 1'b0;
						end
						ADDR_IRQ_ENABLE: begin
							irq_enabled_d = 1'b1;
							irq_pending_d = 1'b0;
						end
						default: ;
					endcase
				end
			end
			REQ_TICK: begin
				// visible line with rendering on: clock the counter
				if (line_s1 <= LAST_VISIBLE_LINE && rend_s1) begin
					if (reload_vblank_q) begin
						cnt             = irq_reload_q;
						reload_vblank_d = 1'b0;
					end
					if (reload_q) begin
						cnt      = irq_reload_q;
						reload_d = 1'b0;
					end else if (cnt != '0) begin
						cnt = cnt - 8'd1;
					end
					if (cnt == '0) begin
						if (irq_enabled_q && irq_reload_q != '0) begin
							irq_pending_d = 1'b1;
							irq_out_d     = 1'b1;
						end
						reload_d = 1'b1;
					end
					irq_count_d = cnt;
				end
			end
			REQ_PRG_QUERY: begin
				if (addr_s1[15]) begin
					case (addr_s1[14:13])
						2'd0:    bank_d = bank_select_q[6] ? second_last : {1'b0, prg_first_q};
						2'd1:    bank_d = {1'b0, prg_second_q};
						2'd2:    bank_d = bank_select_q[6] ? {1'b0, prg_first_q} : second_last;
						default: bank_d = last;
					endcase
				end
			end
			REQ_CHR_QUERY: begin
				if (addr_s1 < ADDR_CHR_END) begin
					is_ram_d = ram;
					bank_d   = ram ? {6'd0, v8[2:0]} : v9;
				end
			end
			REQ_LOW_READ: rd_d = 8'h01;
			default: ;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_count_q <= RST_PRG_BANK_COUNT;
			chr_rom_banks_q  <= RST_CHR_ROM_BANKS;
			four_screen_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRG_BANK_COUNT: prg_bank_count_q <= cfg_data[8:0];
				CFG_CHR_ROM_BANKS:  chr_rom_banks_q  <= cfg_data;
				CFG_FOUR_SCREEN:    four_screen_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Mapper state, updated as each request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q   <= 8'd0;
			chr_pair_a_q    <= 8'd0;
			chr_pair_b_q    <= 8'd2;
			chr_single_q[0] <= 8'd4;
			chr_single_q[1] <= 8'd5;
			chr_single_q[2] <= 8'd6;
			chr_single_q[3] <= 8'd7;
			prg_first_q     <= 8'd0;
			prg_second_q    <= 8'd1;
			chr_low_off_q   <= 1'b0;
			chr_high_off_q  <= 1'b0;
			mirror_q        <= 1'b0;
			irq_enabled_q   <= 1'b0;
			irq_count_q     <= 8'd0;
			irq_reload_q    <= RST_IRQ_RELOAD;
			irq_pending_q   <= 1'b0;
			reload_q        <= 1'b0;
			reload_vblank_q <= 1'b0;
			irq_out_q       <= 1'b0;
		end else if (advance) begin
			bank_select_q   <= bank_select_d;
			chr_pair_a_q    <= chr_pair_a_d;
			chr_pair_b_q    <= chr_pair_b_d;
			chr_single_q    <= chr_single_d;
			prg_first_q     <= prg_first_d;
			prg_second_q    <= prg_second_d;
			chr_low_off_q   <= chr_low_off_d;
			chr_high_off_q  <= chr_high_off_d;
			mirror_q        <= mirror_d;
			irq_enabled_q   <= irq_enabled_d;
			irq_count_q     <= irq_count_d;
			irq_reload_q    <= irq_reload_d;
			irq_pending_q   <= irq_pending_d;
			reload_q        <= reload_d;
			reload_vblank_q <= reload_vblank_d;
			irq_out_q       <= irq_out_d;
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			type_s1 <= req_type;
			addr_s1 <= address;
			data_s1 <= write_data;
			line_s1 <= scanline;
			rend_s1 <= rendering_on;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			bank              <= bank_d;
			bank_is_chr_ram   <= is_ram_d;
			read_data         <= rd_d;
			irq_line          <= irq_out_d;
			mirror_horizontal <= mirror_d;
		end
	end

	// An empty input register never holds off the request side
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("in_stall raised with an empty input register");

	// A result held under stall is not dropped
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("stalled result lost");

	// The IRQ line is only ever driven while interrupts are enabled
	a_irq_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		irq_out_q |-> irq_enabled_q)
		else $error("irq line high with interrupts disabled");

	// A request in the input register stalled only when a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall)
		else $error("input stalled without a waiting result");

endmodule
